// ===== rtl/core/dba_pkg.sv =====
package dba_pkg;

	localparam int NUM_BLOCKS = 1024;
	localparam int MAX_FILES  = 64;
	localparam int BLK_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = BLK_W + 1;
	localparam int OWN_W      = 6;
	localparam int LEN_W      = 11;
	localparam int CFG_W      = 11;
	localparam int OWN_CHK_W  = OWN_W + 1;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1000);

	typedef enum logic [1:0] {
		MODE_RUN    = 2'd0,
		MODE_SINGLE = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_SHORT = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_BAD   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		START_HINT = 2'd0,
		START_S    = 2'd1,
		START_ZERO = 2'd2
	} start_sel_t;

	typedef enum logic [1:0] {
		LIM_M   = 2'd0,
		LIM_LEN = 2'd1,
		LIM_ONE = 2'd2,
		LIM_ALL = 2'd3
	} lim_sel_t;

	typedef enum logic [1:0] {
		RES_HINT = 2'd0,
		RES_S    = 2'd1,
		RES_ZERO = 2'd2,
		RES_READ = 2'd3
	} res_sel_t;

	// one map entry: free bit over owner
	typedef struct packed {
		logic             free;
		logic [OWN_W-1:0] owner;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic       req_load;
		logic       load;
		start_sel_t start_sel;
		lim_sel_t   lim_sel;
		logic       step_rd;
		logic       step_wr;
		logic       wrap_all;
		logic       wr_free;
		logic       cap_s;
		logic       res_load;
		status_t    res_status;
		res_sel_t   res_sel;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		mode_t mode;
		logic  hint_bad;
		logic  len_bad;
		logic  own_bad;
		logic  vld;
		logic  hit;
		logic  miss;
		logic  done;
	} sts_t;

endpackage

// ===== rtl/core/dba_dpath.sv =====
module dba_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dba_pkg::cmd_t                 cmd,
	output dba_pkg::sts_t                 sts,
	input  logic                          cfg_we,
	input  logic [dba_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [1:0]                    in_mode,
	input  logic [dba_pkg::OWN_W-1:0]     in_owner,
	input  logic [dba_pkg::LEN_W-1:0]     in_length,
	input  logic [dba_pkg::BLK_W-1:0]     in_hint,
	output logic [1:0]                    res_status,
	output logic [dba_pkg::BLK_W-1:0]     res_block,
	output logic [dba_pkg::OWN_W-1:0]     res_owner_found,
	output logic                          res_is_free
);

	logic [dba_pkg::CFG_W-1:0] blocks_q;
	dba_pkg::mode_t            mode_q;
	logic [dba_pkg::OWN_W-1:0] owner_q;
	logic [dba_pkg::LEN_W-1:0] len_q;
	logic [dba_pkg::BLK_W-1:0] hint_q;

	logic [dba_pkg::BLK_W-1:0] ptr_q;
	logic [dba_pkg::CNT_W-1:0] cnt_q;
	logic                      vld_s1;
	logic [dba_pkg::BLK_W-1:0] addr_s1;
	logic [dba_pkg::BLK_W-1:0] s_q;

	dba_pkg::entry_t mem [dba_pkg::NUM_BLOCKS];
	dba_pkg::entry_t rdata_q;
	dba_pkg::entry_t wdata;

	logic [dba_pkg::CNT_W-1:0] m_eff;
	logic [dba_pkg::CNT_W-1:0] limit;
	logic [dba_pkg::BLK_W-1:0] start;
	logic [dba_pkg::BLK_W-1:0] ptr_nx;
	logic [dba_pkg::CNT_W-1:0] ptr_inc;
	logic                      more;
	logic                      rd_en;
	logic                      wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q <= dba_pkg::CFG_RESET;
		end else if (cfg_we) begin
			blocks_q <= cfg_wdata;
		end
	end

	// count of 0 acts as 1, above the map size as the map size
	always_comb begin
		if (blocks_q == '0) begin
			m_eff = dba_pkg::CNT_W'(1);
		end else if (blocks_q > dba_pkg::CFG_W'(dba_pkg::NUM_BLOCKS)) begin
			m_eff = dba_pkg::CNT_W'(dba_pkg::NUM_BLOCKS);
		end else begin
			m_eff = dba_pkg::CNT_W'(blocks_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			mode_q  <= dba_pkg::mode_t'(in_mode);
			owner_q <= in_owner;
			len_q   <= in_length;
			hint_q  <= in_hint;
		end
	end

	assign sts.mode     = mode_q;
	assign sts.hint_bad = dba_pkg::CNT_W'(hint_q) >= m_eff;
	assign sts.len_bad  = (len_q == '0) || (dba_pkg::CNT_W'(len_q) > m_eff);
	assign sts.own_bad  = dba_pkg::OWN_CHK_W'(owner_q) >= dba_pkg::OWN_CHK_W'(dba_pkg::MAX_FILES);

	always_comb begin
		unique case (cmd.lim_sel)
			dba_pkg::LIM_M:   limit = m_eff;
			dba_pkg::LIM_LEN: limit = dba_pkg::CNT_W'(len_q);
			dba_pkg::LIM_ONE: limit = dba_pkg::CNT_W'(1);
			dba_pkg::LIM_ALL: limit = dba_pkg::CNT_W'(dba_pkg::NUM_BLOCKS);
			default:          limit = m_eff;
		endcase
	end

	// the first free block is taken straight from the read stage while it is captured
	always_comb begin
		unique case (cmd.start_sel)
			dba_pkg::START_HINT: start = hint_q;
			dba_pkg::START_S:    start = cmd.cap_s ? addr_s1 : s_q;
			dba_pkg::START_ZERO: start = '0;
			default:             start = '0;
		endcase
	end

	assign ptr_inc = dba_pkg::CNT_W'(ptr_q) + dba_pkg::CNT_W'(1);
	always_comb begin
		if (cmd.wrap_all) begin
			ptr_nx = ptr_inc[dba_pkg::BLK_W-1:0];
		end else if (ptr_inc >= m_eff) begin
			ptr_nx = '0;
		end else begin
			ptr_nx = ptr_inc[dba_pkg::BLK_W-1:0];
		end
	end

	assign more  = cnt_q < limit;
	assign rd_en = cmd.step_rd && more && !cmd.load;
	assign wr_en = cmd.step_wr && more && !cmd.load;

	// walker: reset state starts the power-up clearing pass at block 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.load) begin
			ptr_q  <= start;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			if (rd_en || wr_en) begin
				ptr_q <= ptr_nx;
				cnt_q <= cnt_q + dba_pkg::CNT_W'(1);
			end
		end
	end

	always_comb begin
		wdata.free  = cmd.wr_free;
		wdata.owner = cmd.wr_free ? '0 : owner_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ptr_q] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[ptr_q];
			addr_s1 <= ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_s) begin
			s_q <= addr_s1;
		end
	end

	assign sts.vld  = vld_s1;
	assign sts.hit  = vld_s1 && rdata_q.free;
	assign sts.miss = vld_s1 && !rdata_q.free;
	assign sts.done = !more;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status <= cmd.res_status;
			unique case (cmd.res_sel)
				dba_pkg::RES_HINT: begin
					res_block       <= hint_q;
					res_owner_found <= '0;
					res_is_free     <= 1'b0;
				end
				dba_pkg::RES_S: begin
					res_block       <= s_q;
					res_owner_found <= '0;
					res_is_free     <= 1'b0;
				end
				dba_pkg::RES_ZERO: begin
					res_block       <= '0;
					res_owner_found <= '0;
					res_is_free     <= 1'b0;
				end
				dba_pkg::RES_READ: begin
					res_block       <= hint_q;
					res_owner_found <= rdata_q.free ? '0 : rdata_q.owner;
					res_is_free     <= rdata_q.free;
				end
				default: begin
					res_block       <= hint_q;
					res_owner_found <= '0;
					res_is_free     <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/dba_ctrl.sv =====
module dba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  dba_pkg::sts_t sts,
	output dba_pkg::cmd_t cmd,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CHECK,
		S_FIND,
		S_COUNT,
		S_MARK,
		S_READ,
		S_CLEAR,
		S_RESP
	} state_t;

	state_t             state_q;
	state_t             state_nx;
	dba_pkg::status_t   rstat_q;
	dba_pkg::status_t   rstat_nx;
	dba_pkg::res_sel_t  rsel_q;
	dba_pkg::res_sel_t  rsel_nx;
	logic               out_valid_q;
	logic               slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		rstat_nx = rstat_q;
		rsel_nx  = rsel_q;

		cmd            = '0;
		cmd.start_sel  = dba_pkg::START_HINT;
		cmd.lim_sel    = dba_pkg::LIM_M;
		cmd.res_status = rstat_q;
		cmd.res_sel    = rsel_q;

		unique case (state_q)
			S_INIT, S_CLEAR: begin
				cmd.step_wr  = 1'b1;
				cmd.wrap_all = 1'b1;
				cmd.wr_free  = 1'b1;
				cmd.lim_sel  = dba_pkg::LIM_ALL;
				if (sts.done) begin
					if (state_q == S_INIT) begin
						state_nx = S_IDLE;
					end else begin
						state_nx = S_RESP;
						rstat_nx = dba_pkg::STAT_OK;
						rsel_nx  = dba_pkg::RES_ZERO;
					end
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_load = 1'b1;
					state_nx     = S_CHECK;
				end
			end
			S_CHECK: begin
				rsel_nx = dba_pkg::RES_HINT;
				rstat_nx = dba_pkg::STAT_BAD;
				priority if (sts.mode == dba_pkg::MODE_CLEAR) begin
					cmd.load      = 1'b1;
					cmd.start_sel = dba_pkg::START_ZERO;
					state_nx      = S_CLEAR;
				end else if (sts.hint_bad) begin
					state_nx = S_RESP;
				end else if (sts.mode == dba_pkg::MODE_READ) begin
					cmd.load = 1'b1;
					state_nx = S_READ;
				end else if (sts.own_bad) begin
					state_nx = S_RESP;
				end else if (sts.mode == dba_pkg::MODE_RUN && sts.len_bad) begin
					state_nx = S_RESP;
				end else begin
					cmd.load = 1'b1;
					state_nx = S_FIND;
				end
			end
			S_FIND: begin
				cmd.step_rd = 1'b1;
				if (sts.hit) begin
					cmd.cap_s     = 1'b1;
					cmd.load      = 1'b1;
					cmd.start_sel = dba_pkg::START_S;
					state_nx      = (sts.mode == dba_pkg::MODE_SINGLE) ? S_MARK : S_COUNT;
				end else if (!sts.vld && sts.done) begin
					state_nx = S_RESP;
					rstat_nx = dba_pkg::STAT_FULL;
					rsel_nx  = dba_pkg::RES_HINT;
				end
			end
			S_COUNT: begin
				cmd.step_rd = 1'b1;
				cmd.lim_sel = dba_pkg::LIM_LEN;
				if (sts.miss) begin
					state_nx = S_RESP;
					rstat_nx = dba_pkg::STAT_SHORT;
					rsel_nx  = dba_pkg::RES_S;
				end else if (!sts.vld && sts.done) begin
					cmd.load      = 1'b1;
					cmd.start_sel = dba_pkg::START_S;
					state_nx      = S_MARK;
				end
			end
			S_MARK: begin
				cmd.step_wr = 1'b1;
				cmd.lim_sel = (sts.mode == dba_pkg::MODE_SINGLE) ? dba_pkg::LIM_ONE
				                                                 : dba_pkg::LIM_LEN;
				if (sts.done) begin
					state_nx = S_RESP;
					rstat_nx = dba_pkg::STAT_OK;
					rsel_nx  = dba_pkg::RES_S;
				end
			end
			S_READ: begin
				cmd.step_rd = 1'b1;
				cmd.lim_sel = dba_pkg::LIM_ONE;
				if (sts.vld) begin
					state_nx = S_RESP;
					rstat_nx = dba_pkg::STAT_OK;
					rsel_nx  = dba_pkg::RES_READ;
				end
			end
			S_RESP: begin
				if (slot_free) begin
					cmd.res_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			rstat_q     <= dba_pkg::STAT_OK;
			rsel_q      <= dba_pkg::RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			rstat_q <= rstat_nx;
			rsel_q  <= rsel_nx;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/disk_block_allocator_top.sv =====
// Modes: mode 2 clears the whole map, mode 3 reads one entry, a bad request skips the map;
//   modes 0 and 1 walk the block map one block per cycle (single read/write port):
//   a search of up to m blocks for a free one, then in mode 0 a check and a mark of len blocks,
//   in mode 1 a mark of that block alone (m = blocks in use). One request is handled at a time.
// Reset: async active low; then a clearing pass over all NUM_BLOCKS entries frees every block,
//   s_axis_tready stays low meanwhile; blocks_in_use resets to 1000.
module disk_block_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	// config: blocks_in_use
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // owner[5:0], length[16:6], hint[26:17], zero pad
	input  logic [1:0]  s_axis_tuser,   // mode[1:0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // block[9:0], owner_found[15:10], is_free[16], zero pad
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	dba_pkg::cmd_t cmd;
	dba_pkg::sts_t sts;

	logic [1:0]                res_status;
	logic [dba_pkg::BLK_W-1:0] res_block;
	logic [dba_pkg::OWN_W-1:0] res_owner_found;
	logic                      res_is_free;

	// sequencer: request decode, search/count/mark/clear phases, result handoff
	dba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sts       (sts),
		.cmd       (cmd),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	// map memory, block walker, request and result registers
	dba_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_mode         (s_axis_tuser),
		.in_owner        (s_axis_tdata[5:0]),
		.in_length       (s_axis_tdata[16:6]),
		.in_hint         (s_axis_tdata[26:17]),
		.res_status      (res_status),
		.res_block       (res_block),
		.res_owner_found (res_owner_found),
		.res_is_free     (res_is_free)
	);

	// result register holds while the consumer stalls
	assign m_axis_tdata = {7'd0, res_is_free, res_owner_found, res_block};
	assign m_axis_tuser = res_status;

endmodule
